// ===== hw/rtl/rph_pkg.sv =====
`default_nettype none
package rph_pkg;

	localparam int NBINS = 64;
	localparam int BIN_W = $clog2(NBINS);
	localparam int NB_W = 7;
	localparam int MUL_W = 36;
	localparam int PROD_W = 2 * MUL_W;
	localparam int IN_W = 296;
	localparam int OUT_W = 136;

	localparam logic signed [MUL_W-1:0] ONE_Q30 = 36'sd1073741824;
	localparam logic [MUL_W-1:0] C3_LIN = 36'd357913941;
	localparam logic [MUL_W-1:0] C3_LOG = 36'd357913906;
	localparam logic [MUL_W-1:0] C9_Q30 = 36'd95443718;
	localparam logic [MUL_W-1:0] LOG10_2_Q30 = 36'd323228497;

	localparam logic [2:0] CFG_LOG_MODE = 3'd0;
	localparam logic [2:0] CFG_COS_LIMIT = 3'd1;
	localparam logic [2:0] CFG_LIN_SCALE = 3'd2;
	localparam logic [2:0] CFG_LOG_SCALE = 3'd3;
	localparam logic [2:0] CFG_LOG_OFFSET = 3'd4;
	localparam logic [2:0] CFG_NUM_BINS = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_DOT0, S_DOT1, S_DOT2, S_DOT3, S_X2, S_X3, S_T3, S_T9, S_SUM,
		S_SQRT_GO, S_SQRT_WAIT, S_LIN, S_LIN_BIN, S_LOG_GO, S_LOG_WAIT, S_LT,
		S_D, S_LOG_BIN, S_ACC0, S_ACC1, S_ACC2, S_RD0, S_RD1, S_DONE
	} rph_state_t;

	typedef enum logic [1:0] {
		LG_IDLE, LG_NORM, LG_MUL, LG_STEP
	} rph_log_state_t;

	function automatic logic signed [MUL_W-1:0] sx32(input logic [31:0] v);
		return {{(MUL_W-32){v[31]}}, v};
	endfunction

	function automatic logic signed [MUL_W-1:0] zx32(input logic [31:0] v);
		return {{(MUL_W-32){1'b0}}, v};
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rph_isqrt.sv =====
`default_nettype none
module rph_isqrt
	import rph_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] value,
	output logic             done,
	output logic [31:0]      root
);

	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule
`default_nettype wire

// ===== hw/rtl/rph_log2.sv =====
`default_nettype none
module rph_log2
	import rph_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [33:0] value,
	output logic             done,
	output logic [30:0]      result
);

	rph_log_state_t state_q, state_d;
	logic [33:0] norm_q;
	logic [5:0]  shift_q;
	logic [31:0] y_q;
	logic [63:0] prod_q;
	logic [23:0] frac_q;
	logic [4:0]  iter_q;
	logic        done_q;
	logic [32:0] yy;
	logic [6:0]  expo;

	assign yy = prod_q[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == LG_STEP) && (iter_q == 5'd23);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LG_IDLE: begin
				if (start) state_d = LG_NORM;
			end
			LG_NORM: begin
				if (norm_q[33]) state_d = LG_MUL;
			end
			LG_MUL: state_d = LG_STEP;
			LG_STEP: begin
				state_d = (iter_q == 5'd23) ? LG_IDLE : LG_MUL;
			end
			default: state_d = LG_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LG_IDLE: begin
				norm_q <= value;
				shift_q <= '0;
				iter_q <= '0;
				frac_q <= '0;
			end
			LG_NORM: begin
				if (!norm_q[33]) begin
					norm_q <= norm_q << 1;
					shift_q <= shift_q + 6'd1;
				end else begin
					y_q <= norm_q[33:2];
				end
			end
			LG_MUL: prod_q <= {32'd0, y_q} * {32'd0, y_q};
			LG_STEP: begin
				if (yy[32]) begin
					y_q <= yy[32:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					y_q <= yy[31:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
				iter_q <= iter_q + 5'd1;
			end
			default: ;
		endcase
	end

	assign expo = 7'd3 - {1'b0, shift_q};
	assign done = done_q;
	assign result = {expo, frac_q};

endmodule
`default_nettype wire

// ===== hw/rtl/radial_pair_histogram_unit.sv =====
// Weighted angular-separation histogram with 64 saturating bin pairs.
// Input beats arrive on s_axis: tuser selects accumulate (0) or read-and-clear
// (1); tdata carries the two unit vectors, weight, field and mask values and
// the bin to read. Each beat gives exactly one m_axis beat with the accepted
// flag, the bin index and, for a read, the bin's two Q32.32 sums.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no beat is in flight.
// One beat is processed at a time through a shared 36x36 multiplier and a
// sequencer; s_axis_tready is high only while the sequencer is idle.
// A read goes straight to its result; a rejected pair stops after the dot
// product; a kept pair runs the angle polynomial, then the square root or the
// log2 unit (linear or log bins). The square root takes its 32 steps; the log2
// unit takes 24 squaring steps after a normalizing shift that grows as the
// angle shrinks. The one-port bin stores are read in S_ACC0 and written back in
// S_ACC2 for a pair, and for a read in the cycle before its clearing write.
// Reset clears the registers to their defaults and marks every bin empty at
// once, so no clearing pass is needed. When m_axis_tready is low the finished
// result waits in the output register; the next beat is accepted and processed
// but holds before its result until the output register is free.
`default_nettype none
module radial_pair_histogram_unit
	import rph_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// obj_x, obj_y, obj_z, obj_weight, pix_x, pix_y, pix_z, field_value,
	// mask_value, read_bin, two zero bits
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	// op
	input  wire logic              s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// accepted, bin_index, field_sum, mask_sum, one zero bit
	output logic [OUT_W-1:0]       m_axis_tdata,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);

	rph_state_t state_q, state_d;

	logic        log_mode_q;
	logic [31:0] cos_limit_q;
	logic [31:0] lin_scale_q;
	logic [31:0] log_scale_q;
	logic [31:0] log_offset_q;
	logic [NB_W-1:0] num_bins_q;
	logic [NB_W-1:0] nb;

	logic [IN_W-1:0] in_q;
	logic            op_q;
	logic [31:0] obj_x, obj_y, obj_z, obj_weight, pix_x, pix_y, pix_z;
	logic [31:0] field_value, mask_value;
	logic [BIN_W-1:0] read_bin;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_q;

	logic signed [MUL_W-1:0] dot_q, dot, term, clamp;
	logic [31:0] x_q;
	logic [32:0] x2_q;
	logic [33:0] x3_q;
	logic [31:0] t3_q;
	logic [33:0] s_q;
	logic [31:0] th_q;
	logic [30:0] l2_q;
	logic        neg_q;
	logic signed [34:0] d_full;
	logic [34:0] d_mag;
	logic [BIN_W-1:0] bin_q;
	logic [17:0] lin_bin;
	logic [24:0] q_mag;
	logic signed [26:0] log_bin;
	logic        reject_dot;
	logic        lin_ok, log_ok;

	logic [63:0] pf_q;
	logic        res_acc_q;
	logic [BIN_W-1:0] res_bin_q;
	logic [63:0] res_f_q, res_m_q;
	logic        out_valid_q, out_acc_q;
	logic [BIN_W-1:0] out_bin_q;
	logic [63:0] out_f_q, out_m_q;

	logic [63:0] field_mem [NBINS];
	logic [63:0] mask_mem [NBINS];
	logic [NBINS-1:0] valid_q;
	logic [63:0] rd_f_q, rd_m_q;
	logic        rd_v_q;
	logic [63:0] rd_f, rd_m;
	logic        mem_re, mem_we;
	logic [BIN_W-1:0] mem_addr;
	logic [63:0] wr_f, wr_m;

	logic sqrt_start, sqrt_done, log_start, log_done;
	logic [31:0] sqrt_root;
	logic [30:0] log_res;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

	assign obj_x = in_q[31:0];
	assign obj_y = in_q[63:32];
	assign obj_z = in_q[95:64];
	assign obj_weight = in_q[127:96];
	assign pix_x = in_q[159:128];
	assign pix_y = in_q[191:160];
	assign pix_z = in_q[223:192];
	assign field_value = in_q[255:224];
	assign mask_value = in_q[287:256];
	assign read_bin = in_q[293:288];

	assign nb = (num_bins_q > NB_W'(NBINS)) ? NB_W'(NBINS) : num_bins_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_mode_q <= 1'b0;
			cos_limit_q <= 32'd1073741823;
			lin_scale_q <= 32'd65536;
			log_scale_q <= 32'd65536;
			log_offset_q <= 32'd0;
			num_bins_q <= NB_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOG_MODE: log_mode_q <= cfg_data[0];
				CFG_COS_LIMIT: cos_limit_q <= cfg_data;
				CFG_LIN_SCALE: lin_scale_q <= cfg_data;
				CFG_LOG_SCALE: log_scale_q <= cfg_data;
				CFG_LOG_OFFSET: log_offset_q <= cfg_data;
				CFG_NUM_BINS: num_bins_q <= cfg_data[NB_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath terms
	assign term = {{2{mul_q[63]}}, mul_q[63:30]};
	assign dot = dot_q + term;
	assign reject_dot = (dot <= sx32(cos_limit_q)) || (log_mode_q && dot >= ONE_Q30);
	always_comb begin
		if (dot > ONE_Q30) clamp = ONE_Q30;
		else if (dot < -ONE_Q30) clamp = -ONE_Q30;
		else clamp = dot;
	end

	assign lin_bin = mul_q[63:46];
	assign lin_ok = lin_bin < {11'd0, nb};

	assign d_full = {{2{mul_q[63]}}, mul_q[63:31]} - {{3{log_offset_q[31]}}, log_offset_q};
	assign d_mag = d_full[34] ? 35'(-d_full) : d_full;
	assign q_mag = {1'b0, mul_q[63:40]} + {24'd0, neg_q && (mul_q[39:0] != '0)};
	assign log_bin = neg_q ? ($signed({20'd0, nb}) - $signed({2'd0, q_mag}))
	                       : ($signed({20'd0, nb}) + $signed({2'd0, q_mag}));
	assign log_ok = !log_bin[26] && (log_bin < $signed({20'd0, nb}));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		sqrt_start = 1'b0;
		log_start = 1'b0;
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_addr = bin_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = s_axis_tuser ? S_RD0 : S_DOT0;
			end
			S_DOT0: begin
				mul_a = sx32(obj_x);
				mul_b = sx32(pix_x);
				state_d = S_DOT1;
			end
			S_DOT1: begin
				mul_a = sx32(obj_y);
				mul_b = sx32(pix_y);
				state_d = S_DOT2;
			end
			S_DOT2: begin
				mul_a = sx32(obj_z);
				mul_b = sx32(pix_z);
				state_d = S_DOT3;
			end
			S_DOT3: state_d = reject_dot ? S_DONE : S_X2;
			S_X2: begin
				mul_a = zx32(x_q);
				mul_b = zx32(x_q);
				state_d = S_X3;
			end
			S_X3: begin
				mul_a = {3'd0, mul_q[62:30]};
				mul_b = zx32(x_q);
				state_d = S_T3;
			end
			S_T3: begin
				mul_a = {3'd0, x2_q};
				mul_b = log_mode_q ? C3_LOG : C3_LIN;
				state_d = S_T9;
			end
			S_T9: begin
				mul_a = {2'd0, x3_q};
				mul_b = C9_Q30;
				state_d = S_SUM;
			end
			S_SUM: state_d = log_mode_q ? S_LOG_GO : S_SQRT_GO;
			S_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_d = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (sqrt_done) state_d = S_LIN;
			end
			S_LIN: begin
				mul_a = zx32(th_q);
				mul_b = zx32(lin_scale_q);
				state_d = S_LIN_BIN;
			end
			S_LIN_BIN: state_d = lin_ok ? S_ACC0 : S_DONE;
			S_LOG_GO: begin
				log_start = 1'b1;
				state_d = S_LOG_WAIT;
			end
			S_LOG_WAIT: begin
				if (log_done) state_d = S_LT;
			end
			S_LT: begin
				mul_a = {{5{l2_q[30]}}, l2_q};
				mul_b = LOG10_2_Q30;
				state_d = S_D;
			end
			S_D: begin
				mul_a = zx32(d_mag[31:0]);
				mul_b = zx32(log_scale_q);
				state_d = S_LOG_BIN;
			end
			S_LOG_BIN: state_d = log_ok ? S_ACC0 : S_DONE;
			S_ACC0: begin
				mem_re = 1'b1;
				mul_a = sx32(obj_weight);
				mul_b = sx32(field_value);
				state_d = S_ACC1;
			end
			S_ACC1: begin
				mul_a = sx32(obj_weight);
				mul_b = sx32(mask_value);
				state_d = S_ACC2;
			end
			S_ACC2: begin
				mem_we = 1'b1;
				state_d = S_DONE;
			end
			S_RD0: begin
				mem_re = 1'b1;
				mem_addr = read_bin;
				state_d = S_RD1;
			end
			S_RD1: begin
				mem_we = 1'b1;
				mem_addr = read_bin;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				in_q <= s_axis_tdata;
				op_q <= s_axis_tuser;
			end
			S_DOT1: dot_q <= term;
			S_DOT2: dot_q <= dot;
			S_DOT3: begin
				x_q <= 32'(ONE_Q30 - clamp);
				res_acc_q <= 1'b0;
				res_bin_q <= '0;
				res_f_q <= '0;
				res_m_q <= '0;
			end
			S_X3: x2_q <= mul_q[62:30];
			S_T3: x3_q <= mul_q[63:30];
			S_T9: t3_q <= mul_q[61:30];
			S_SUM: s_q <= {1'b0, x_q, 1'b0} + {2'd0, t3_q} + {2'd0, mul_q[61:30]};
			S_SQRT_WAIT: th_q <= sqrt_root;
			S_LIN_BIN: bin_q <= lin_bin[BIN_W-1:0];
			S_LOG_WAIT: l2_q <= log_res;
			S_D: neg_q <= d_full[34];
			S_LOG_BIN: bin_q <= log_bin[BIN_W-1:0];
			S_ACC1: pf_q <= mul_q[63:0];
			S_ACC2: begin
				res_acc_q <= 1'b1;
				res_bin_q <= bin_q;
			end
			S_RD1: begin
				res_acc_q <= 1'b0;
				res_bin_q <= read_bin;
				res_f_q <= rd_f;
				res_m_q <= rd_m;
			end
			default: ;
		endcase
	end

	// Bin stores
	assign rd_f = rd_v_q ? rd_f_q : 64'd0;
	assign rd_m = rd_v_q ? rd_m_q : 64'd0;
	assign wr_f = (state_q == S_RD1) ? 64'd0 : sat_add(rd_f, pf_q);
	assign wr_m = (state_q == S_RD1) ? 64'd0 : sat_add(rd_m, mul_q[63:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			field_mem[mem_addr] <= wr_f;
			mask_mem[mem_addr] <= wr_m;
		end
		if (mem_re) begin
			rd_f_q <= field_mem[mem_addr];
			rd_m_q <= mask_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_v_q <= 1'b0;
		end else begin
			if (mem_we) valid_q[mem_addr] <= 1'b1;
			if (mem_re) rd_v_q <= valid_q[mem_addr];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
			out_acc_q <= res_acc_q;
			out_bin_q <= res_bin_q;
			out_f_q <= res_f_q;
			out_m_q <= res_m_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_m_q, out_f_q, out_bin_q, out_acc_q};

	rph_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  ({s_q, 30'd0}),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	rph_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.value  (s_q),
		.done   (log_done),
		.result (log_res)
	);

`ifndef SYNTH
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
		else $error("accepted beat did not start the sequencer");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == S_DONE))
		else $error("result loaded outside the done step");
	a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == S_SQRT_WAIT))
		else $error("square root finished while not awaited");
	a_log_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		log_done |-> (state_q == S_LOG_WAIT))
		else $error("log2 finished while not awaited");
	a_rd_op_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD1) |-> op_q)
		else $error("read step reached by an accumulate beat");
`endif

endmodule
`default_nettype wire
